// File: rtl/rwct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwct_pkg: shared definitions for the read/write conflict table
// Field widths, access kind and outcome codes, hash constant, table entry
// layout, probe cell result and controller state type.
// ----------------------------------------------------------------------------
package rwct_pkg;

	localparam int LOG_ENTRIES_DEF = 8;
	localparam int MAX_PROBES_DEF  = 4;

	localparam int TAG_W   = 32;
	localparam int KEY_W   = 64;
	localparam int TXN_W   = 16;
	localparam int KIND_W  = 2;
	localparam int OUTC_W  = 2;

	// golden-ratio multiplier, split in 32-bit halves
	localparam logic [TAG_W-1:0] HASH_MUL_HI = 32'h9E37_79B9;
	localparam logic [TAG_W-1:0] HASH_MUL_LO = 32'h7F4A_7C15;

	localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SHARED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd2;

	localparam logic [OUTC_W-1:0] OUT_GRANTED  = 2'd0;
	localparam logic [OUTC_W-1:0] OUT_CONFLICT = 2'd1;
	localparam logic [OUTC_W-1:0] OUT_FULL     = 2'd2;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  loc;
		logic [TXN_W-1:0]  owner;
		logic [KIND_W-1:0] kind;
	} entry_t;

	// what a probe cell reports when it settles the lookup
	typedef struct packed {
		logic              fire;
		logic              hit;
		logic [TXN_W-1:0]  owner;
		logic [KIND_W-1:0] kind;
	} cell_res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_DONE
	} st_t;

endpackage
`default_nettype wire

// File: rtl/rwct_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwct_hash: multiplicative home-slot hash
// Low 64 bits of key * golden constant from three 32x32 products on one
// shared multiplier; home slot is the top LOG_ENTRIES bits.
// ----------------------------------------------------------------------------
module rwct_hash
	import rwct_pkg::*;
#(
	parameter int LOG_ENTRIES = LOG_ENTRIES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [KEY_W-1:0]       key,
	output logic                        done,
	output logic [LOG_ENTRIES-1:0]      home
);

	logic              busy_q;
	logic [1:0]        step_q;
	logic              done_q;
	logic [1:0]        step_cur;
	logic [TAG_W-1:0]  op_a;
	logic [TAG_W-1:0]  op_b;
	logic [KEY_W-1:0]  prod_s1;
	logic [TAG_W-1:0]  acc_q;
	logic              run;

	assign run      = start | busy_q;
	assign step_cur = start ? 2'd0 : step_q;

	// step 0: lo*lo, step 1: hi*lo, step 2: lo*hi (only low halves of the cross terms)
	always_comb begin
		case (step_cur)
			2'd1: begin
				op_a = key[KEY_W-1:TAG_W];
				op_b = HASH_MUL_LO;
			end
			2'd2: begin
				op_a = key[TAG_W-1:0];
				op_b = HASH_MUL_HI;
			end
			default: begin
				op_a = key[TAG_W-1:0];
				op_b = HASH_MUL_LO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd1;
			end else if (busy_q) begin
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			prod_s1 <= KEY_W'(op_a) * KEY_W'(op_b);
			case (step_cur)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= prod_s1[KEY_W-1:TAG_W];
				default: acc_q <= acc_q + prod_s1[TAG_W-1:0];
			endcase
		end
	end

	assign done = done_q;
	assign home = acc_q[TAG_W-1 -: LOG_ENTRIES];

endmodule
`default_nettype wire

// File: rtl/rwct_probe_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwct_probe_cell: one probe of the linear-probing lookup
// Holds the probe token for its slot, checks the entry read for it, and
// either settles the lookup or hands the next slot to its neighbor.
// ----------------------------------------------------------------------------
module rwct_probe_cell
	import rwct_pkg::*;
#(
	parameter int LOG_ENTRIES = LOG_ENTRIES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   tok_act,
	input  wire logic [LOG_ENTRIES-1:0] tok_addr,
	input  wire logic [KEY_W-1:0]       key,
	input  wire entry_t                 rd_entry,
	output logic                        pass_act,
	output logic [LOG_ENTRIES-1:0]      pass_addr,
	output cell_res_t                   res,
	output logic [LOG_ENTRIES-1:0]      res_slot
);

	logic                   act_q;
	logic [LOG_ENTRIES-1:0] addr_q;
	logic                   miss;
	logic                   hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= tok_act;
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= tok_addr;
	end

	// free slot ends the search; matching key is a hit
	assign miss = !rd_entry.valid;
	assign hit  = rd_entry.valid && (rd_entry.loc == key);

	assign pass_act  = act_q && !miss && !hit;
	assign pass_addr = addr_q + LOG_ENTRIES'(1);

	assign res.fire  = act_q && (miss || hit);
	assign res.hit   = hit;
	assign res.owner = rd_entry.owner;
	assign res.kind  = rd_entry.kind;
	assign res_slot  = addr_q;

endmodule
`default_nettype wire

// File: rtl/rwct_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwct_table: entry storage
// One write port, one registered read port; sweeps all entries invalid
// after reset.
// ----------------------------------------------------------------------------
module rwct_table
	import rwct_pkg::*;
#(
	parameter int LOG_ENTRIES = LOG_ENTRIES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   we,
	input  wire logic [LOG_ENTRIES-1:0] waddr,
	input  wire entry_t                 wdata,
	input  wire logic [LOG_ENTRIES-1:0] raddr,
	output entry_t                      rdata,
	output logic                        clr_busy
);

	localparam int ENTRIES = 1 << LOG_ENTRIES;

	entry_t                 mem [ENTRIES];
	entry_t                 rdata_q;
	logic                   clearing_q;
	logic [LOG_ENTRIES-1:0] clr_cnt_q;
	logic                   mem_we;
	logic [LOG_ENTRIES-1:0] mem_addr;
	entry_t                 mem_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + LOG_ENTRIES'(1);
			if (clr_cnt_q == {LOG_ENTRIES{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign mem_we   = clearing_q | we;
	assign mem_addr = clearing_q ? clr_cnt_q : waddr;
	assign mem_data = clearing_q ? entry_t'('0) : wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata    = rdata_q;
	assign clr_busy = clearing_q;

endmodule
`default_nettype wire

// File: rtl/read_write_conflict_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// read_write_conflict_table_top: read/write-set conflict detector
// Grants or refuses serialized load/store accesses of transactions to
// (contract, slot) locations, tracked in a hashed owner/kind table.
// ----------------------------------------------------------------------------
// One access at a time. After the input transfer the 64-bit location is
// hashed on a single shared 32x32 multiplier (four steps), then a chain of
// MAX_PROBES probe cells walks the table, one slot per cycle through the
// table's single registered read port, until a free or matching slot is
// found or the probe path is exhausted (table full). The done state applies
// the read/write rules, writes the entry back and loads the result register.
// An access examines p slots (1..MAX_PROBES, MAX_PROBES when full); the
// result register lets the next access start while the previous outcome
// still waits on out_stall. After reset the table is swept invalid one
// entry per cycle, with in_stall held high.
// outcome: 0 granted, 1 refused by conflict, 2 refused because full.
// ----------------------------------------------------------------------------
module read_write_conflict_table_top
	import rwct_pkg::*;
#(
	parameter int LOG_ENTRIES = LOG_ENTRIES_DEF,
	parameter int MAX_PROBES  = MAX_PROBES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// access channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              mode,
	input  wire logic [TAG_W-1:0]  contract_tag,
	input  wire logic [TAG_W-1:0]  slot_tag,
	input  wire logic [TXN_W-1:0]  txn_id,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [OUTC_W-1:0]      outcome
);

	st_t state_q;
	st_t state_d;

	// latched access
	logic              mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [TXN_W-1:0]  txn_q;
	logic              hash_go_q;

	// FSM strobes
	logic accept;
	logic launch;
	logic capture;
	logic load_out;

	// hash
	logic                   hash_done;
	logic [LOG_ENTRIES-1:0] home;

	// table
	logic                   tbl_we;
	entry_t                 tbl_wdata;
	logic [LOG_ENTRIES-1:0] tbl_raddr;
	entry_t                 tbl_rdata;
	logic                   clr_busy;

	// probe chain
	logic                   pass_act  [MAX_PROBES];
	logic [LOG_ENTRIES-1:0] pass_addr [MAX_PROBES];
	cell_res_t              cell_res  [MAX_PROBES];
	logic [LOG_ENTRIES-1:0] cell_slot [MAX_PROBES];

	logic                   any_fire;
	logic                   path_full;
	logic                   sel_hit;
	logic [LOG_ENTRIES-1:0] sel_slot;
	logic [TXN_W-1:0]       sel_owner;
	logic [KIND_W-1:0]      sel_kind;

	// captured lookup result
	logic                   cap_full_q;
	logic                   cap_hit_q;
	logic [LOG_ENTRIES-1:0] cap_slot_q;
	logic [TXN_W-1:0]       cap_owner_q;
	logic [KIND_W-1:0]      cap_kind_q;

	// decision
	logic              same_owner;
	logic [OUTC_W-1:0] dec_outcome;
	logic              dec_we;
	logic [TXN_W-1:0]  dec_owner;
	logic [KIND_W-1:0] dec_kind;

	// result register
	logic              out_valid_q;
	logic [OUTC_W-1:0] outcome_q;

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		launch   = 1'b0;
		capture  = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (!clr_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = ST_HASH;
				end
			end
			ST_HASH: begin
				if (hash_done) begin
					launch  = 1'b1;
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (any_fire || path_full) begin
					capture = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait only if the previous outcome is still held
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_go_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			hash_go_q   <= accept;
			out_valid_q <= load_out | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= {contract_tag, slot_tag};
			txn_q  <= txn_id;
		end
		if (capture) begin
			cap_full_q  <= path_full && !any_fire;
			cap_hit_q   <= sel_hit;
			cap_slot_q  <= sel_slot;
			cap_owner_q <= sel_owner;
			cap_kind_q  <= sel_kind;
		end
		if (load_out) begin
			outcome_q <= dec_outcome;
		end
	end

	// ------------------------------------------------------------------- hash
	rwct_hash #(
		.LOG_ENTRIES (LOG_ENTRIES)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_go_q),
		.key    (key_q),
		.done   (hash_done),
		.home   (home)
	);

	// ------------------------------------------------------------ probe chain
	// Cell 0 gets the home slot; each cell passes slot+1 on when its entry is
	// neither free nor a match. At most one cell holds the token.
	for (genvar gi = 0; gi < MAX_PROBES; gi++) begin : g_cell
		logic                   tok_act;
		logic [LOG_ENTRIES-1:0] tok_addr;
		if (gi == 0) begin : g_head
			assign tok_act  = launch;
			assign tok_addr = home;
		end else begin : g_link
			assign tok_act  = pass_act[gi-1];
			assign tok_addr = pass_addr[gi-1];
		end
		rwct_probe_cell #(
			.LOG_ENTRIES (LOG_ENTRIES)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_act   (tok_act),
			.tok_addr  (tok_addr),
			.key       (key_q),
			.rd_entry  (tbl_rdata),
			.pass_act  (pass_act[gi]),
			.pass_addr (pass_addr[gi]),
			.res       (cell_res[gi]),
			.res_slot  (cell_slot[gi])
		);
	end

	// read address follows the token; select the settling cell's report
	always_comb begin
		tbl_raddr = launch ? home : '0;
		any_fire  = 1'b0;
		sel_hit   = 1'b0;
		sel_slot  = '0;
		sel_owner = '0;
		sel_kind  = '0;
		for (int i = 0; i < MAX_PROBES; i++) begin
			tbl_raddr = tbl_raddr | ({LOG_ENTRIES{pass_act[i]}} & pass_addr[i]);
			any_fire  = any_fire | cell_res[i].fire;
			sel_hit   = sel_hit | (cell_res[i].fire & cell_res[i].hit);
			sel_slot  = sel_slot | ({LOG_ENTRIES{cell_res[i].fire}} & cell_slot[i]);
			sel_owner = sel_owner | ({TXN_W{cell_res[i].fire}} & cell_res[i].owner);
			sel_kind  = sel_kind | ({KIND_W{cell_res[i].fire}} & cell_res[i].kind);
		end
	end

	// token ran off the last cell: no free or matching slot on the path
	assign path_full = pass_act[MAX_PROBES-1];

	// --------------------------------------------------------------- decision
	assign same_owner = (cap_owner_q == txn_q);

	always_comb begin
		dec_outcome = OUT_GRANTED;
		dec_we      = 1'b0;
		dec_owner   = cap_owner_q;
		dec_kind    = cap_kind_q;
		if (cap_full_q) begin
			dec_outcome = OUT_FULL;
		end else if (!cap_hit_q) begin
			// miss: insert
			dec_we    = 1'b1;
			dec_owner = txn_q;
			dec_kind  = mode_q ? KIND_WRITE : KIND_READ;
		end else if (!mode_q) begin
			if (same_owner || cap_kind_q == KIND_SHARED) begin
				dec_outcome = OUT_GRANTED;
			end else if (cap_kind_q == KIND_READ) begin
				// another reader: convert to shared, new owner
				dec_we    = 1'b1;
				dec_owner = txn_q;
				dec_kind  = KIND_SHARED;
			end else begin
				dec_outcome = OUT_CONFLICT;
			end
		end else begin
			if (!same_owner || cap_kind_q == KIND_SHARED) begin
				dec_outcome = OUT_CONFLICT;
			end else if (cap_kind_q == KIND_READ) begin
				// own read upgraded to write
				dec_we   = 1'b1;
				dec_kind = KIND_WRITE;
			end else begin
				dec_outcome = OUT_GRANTED;
			end
		end
	end

	assign tbl_we          = load_out & dec_we;
	assign tbl_wdata.valid = 1'b1;
	assign tbl_wdata.loc   = key_q;
	assign tbl_wdata.owner = dec_owner;
	assign tbl_wdata.kind  = dec_kind;

	// ------------------------------------------------------------------ table
	rwct_table #(
		.LOG_ENTRIES (LOG_ENTRIES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (tbl_we),
		.waddr    (cap_slot_q),
		.wdata    (tbl_wdata),
		.raddr    (tbl_raddr),
		.rdata    (tbl_rdata),
		.clr_busy (clr_busy)
	);

	assign out_valid = out_valid_q;
	assign outcome   = outcome_q;

	// ------------------------------------------------------------- assertions
`ifndef NO_ASSERTIONS
	// head cell never passes and settles at once, and is empty at launch
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({pass_act[0], cell_res[0].fire, launch}))
	else $error("probe token duplicated");

	// a table write always comes with a result transfer being offered
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |=> out_valid)
	else $error("table written without a result");

	// hash only completes while the controller waits for it
	a_hash_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == ST_HASH)
	else $error("hash finished outside hash state");

	// no access is taken while the table is being swept
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> in_stall)
	else $error("access accepted during table clear");
`endif

endmodule
`default_nettype wire
